[rtl/core/neighbor_address_cache_top_macros.svh]
// Assertion helpers for the top-level block, which checks itself.
`ifndef NEIGHBOR_ADDRESS_CACHE_TOP_MACROS_SVH
`define NEIGHBOR_ADDRESS_CACHE_TOP_MACROS_SVH

// Property checked at every edge outside reset.
`define NAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define NAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

[rtl/core/nac_pkg.sv]
package nac_pkg;

  // input command codes
  localparam logic [2:0] CMD_LOOKUP  = 3'd0;
  localparam logic [2:0] CMD_REFRESH = 3'd1;
  localparam logic [2:0] CMD_ENTER   = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_FLUSH   = 3'd4;

  // internal operation classes
  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_REFRESH = 3'd1;
  localparam logic [2:0] OP_ENTER   = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_IGNORE  = 3'd5;

  // result status codes
  localparam logic [3:0] ST_RESOLVED     = 4'd0;
  localparam logic [3:0] ST_STALE        = 4'd1;
  localparam logic [3:0] ST_PENDING_NEW  = 4'd2;
  localparam logic [3:0] ST_PENDING_OLD  = 4'd3;
  localparam logic [3:0] ST_UPDATED      = 4'd4;
  localparam logic [3:0] ST_ADDED        = 4'd5;
  localparam logic [3:0] ST_IGNORED      = 4'd6;
  localparam logic [3:0] ST_DELETED      = 4'd7;
  localparam logic [3:0] ST_DELETE_MISS  = 4'd8;
  localparam logic [3:0] ST_FLUSHED      = 4'd9;

  // entry state codes
  localparam logic [1:0] ES_UNUSED   = 2'd0;
  localparam logic [1:0] ES_RESOLVED = 2'd1;
  localparam logic [1:0] ES_WAITING  = 2'd2;

  localparam int unsigned STALE_RESET = 15 * 60 * 1000;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [2:0]  media;
    logic [47:0] mac;
    logic [31:0] use_time;
    logic [31:0] confirm_time;
  } entry_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [2:0]  media;
    logic [47:0] mac;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic init_done;
    logic idle;
  } back_stat_t;

endpackage

[rtl/core/nac_front.sv]
module nac_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [215:0]        s_tdata,
  input  logic [2:0]          s_tuser,
  input  nac_pkg::back_stat_t stat,
  input  logic                q_full,
  output logic                push,
  output nac_pkg::req_t       push_req
);

  logic [2:0] op;

  always_comb begin
    case (s_tuser)
      nac_pkg::CMD_LOOKUP:  op = nac_pkg::OP_LOOKUP;
      nac_pkg::CMD_REFRESH: op = nac_pkg::OP_REFRESH;
      nac_pkg::CMD_ENTER:   op = nac_pkg::OP_ENTER;
      nac_pkg::CMD_DELETE:  op = nac_pkg::OP_DELETE;
      nac_pkg::CMD_FLUSH:   op = nac_pkg::OP_FLUSH;
      default:              op = nac_pkg::OP_IGNORE;
    endcase
  end

  // nothing enters while the table sweep after reset runs
  assign s_tready = stat.init_done && !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_req.op        = op;
    push_req.addr_high = s_tdata[63:0];
    push_req.addr_low  = s_tdata[127:64];
    push_req.media     = s_tdata[130:128];
    push_req.mac       = s_tdata[178:131];
    push_req.now       = s_tdata[210:179];
  end

endmodule

[rtl/core/nac_queue.sv]
module nac_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nac_pkg::req_t push_req,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output logic [1:0]    q_count,
  output nac_pkg::req_t q_head
);

  nac_pkg::req_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;

  assign q_valid = q_count != 2'd0;
  assign q_full  = q_count == 2'd2;
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

[rtl/core/nac_back.sv]
module nac_back #(
  parameter int ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         stale_age,
  input  logic                q_valid,
  input  nac_pkg::req_t       q_head,
  output logic                pop,
  output nac_pkg::back_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic [3:0]          m_tuser
);

  localparam int AW = $clog2(ENTRIES);
  localparam int IW = (AW > 8) ? AW : 8;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]       state;
  logic             init_done;
  logic [AW:0]      cnt;
  logic             issuing;
  logic             rd_vld;
  logic [AW-1:0]    rd_idx;
  nac_pkg::entry_t  mem [ENTRIES];
  nac_pkg::entry_t  rdata;
  nac_pkg::req_t    req;

  logic             found;
  logic [AW-1:0]    hit_idx;
  nac_pkg::entry_t  hit_ent;
  logic             best_seen;
  logic [31:0]      best_time;
  logic [AW-1:0]    best_idx;
  logic             best_live;

  logic             we;
  logic [AW-1:0]    waddr;
  nac_pkg::entry_t  wdata;

  logic [3:0]       res_status, res_status_next;
  logic [47:0]      res_mac, res_mac_next;
  logic [AW-1:0]    res_idx, res_idx_next;
  logic             res_live, res_live_next;
  logic [IW-1:0]    res_idx_ext;

  logic             addr_eq;
  logic             match;
  logic [31:0]      age;

  assign issuing = (state == S_SCAN) && (cnt < (AW+1)'(ENTRIES));
  assign pop     = (state == S_IDLE) && q_valid;
  assign stat.init_done = init_done;
  assign stat.idle      = (state == S_IDLE);

  assign addr_eq = (rdata.addr_high == req.addr_high) && (rdata.addr_low == req.addr_low);

  always_comb begin
    case (req.op)
      nac_pkg::OP_LOOKUP:
        match = (rdata.status != nac_pkg::ES_UNUSED) && addr_eq &&
                (rdata.media == req.media);
      nac_pkg::OP_DELETE:
        match = (rdata.status != nac_pkg::ES_UNUSED) && addr_eq;
      default:
        match = ((rdata.status == nac_pkg::ES_RESOLVED) ||
                 (rdata.status == nac_pkg::ES_WAITING)) && addr_eq &&
                (rdata.media == req.media);
    endcase
  end

  assign age = req.now - hit_ent.confirm_time;

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[issuing ? cnt[AW-1:0] : '0];
  end

  // write port and result selection
  always_comb begin
    we              = 1'b0;
    waddr           = hit_idx;
    wdata           = '0;
    res_status_next = nac_pkg::ST_IGNORED;
    res_mac_next    = '0;
    res_idx_next    = '0;
    res_live_next   = 1'b0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[AW-1:0];
      end
      S_SCAN: begin
        if (rd_vld && match && (req.op == nac_pkg::OP_DELETE)) begin
          we    = 1'b1;
          waddr = rd_idx;
        end
      end
      S_FINISH: begin
        case (req.op)
          nac_pkg::OP_LOOKUP: begin
            if (found) begin
              we           = 1'b1;
              wdata        = hit_ent;
              wdata.use_time = req.now;
              res_idx_next = hit_idx;
              if (hit_ent.status == nac_pkg::ES_WAITING) begin
                res_status_next = nac_pkg::ST_PENDING_OLD;
              end else if (age > stale_age) begin
                wdata           = '0;
                res_status_next = nac_pkg::ST_STALE;
                res_mac_next    = hit_ent.mac;
              end else begin
                res_status_next = nac_pkg::ST_RESOLVED;
                res_mac_next    = hit_ent.mac;
              end
            end else begin
              we              = 1'b1;
              waddr           = best_idx;
              wdata.status    = nac_pkg::ES_WAITING;
              wdata.addr_high = req.addr_high;
              wdata.addr_low  = req.addr_low;
              wdata.media     = req.media;
              wdata.use_time  = req.now;
              res_status_next = nac_pkg::ST_PENDING_NEW;
              res_idx_next    = best_idx;
              res_live_next   = best_live;
            end
          end
          nac_pkg::OP_REFRESH, nac_pkg::OP_ENTER: begin
            wdata.status       = nac_pkg::ES_RESOLVED;
            wdata.addr_high    = req.addr_high;
            wdata.addr_low     = req.addr_low;
            wdata.media        = req.media;
            wdata.mac          = req.mac;
            wdata.use_time     = req.now;
            wdata.confirm_time = req.now;
            if (found) begin
              we              = 1'b1;
              res_status_next = nac_pkg::ST_UPDATED;
              res_mac_next    = req.mac;
              res_idx_next    = hit_idx;
            end else if (req.op == nac_pkg::OP_ENTER) begin
              we              = 1'b1;
              waddr           = best_idx;
              res_status_next = nac_pkg::ST_ADDED;
              res_mac_next    = req.mac;
              res_idx_next    = best_idx;
              res_live_next   = best_live;
            end
          end
          nac_pkg::OP_DELETE: begin
            res_status_next = found ? nac_pkg::ST_DELETED : nac_pkg::ST_DELETE_MISS;
            res_idx_next    = found ? hit_idx : '0;
          end
          nac_pkg::OP_FLUSH: begin
            res_status_next = nac_pkg::ST_FLUSHED;
          end
          default: begin
            res_status_next = nac_pkg::ST_IGNORED;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign res_idx_ext = IW'(res_idx);

  always_ff @(posedge clk) begin
    if (pop) begin
      req <= q_head;
    end
    if (state == S_FINISH) begin
      res_status <= res_status_next;
      res_mac    <= res_mac_next;
      res_idx    <= res_idx_next;
      res_live   <= res_live_next;
    end
    if (state == S_RESP && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_live, res_idx_ext[7:0], res_mac};
    end
    // scan trackers: first match, and oldest use time with lowest index on ties
    if (pop) begin
      best_seen <= 1'b0;
      best_time <= '0;
      best_idx  <= '0;
      best_live <= 1'b0;
      hit_idx   <= '0;
      hit_ent   <= '0;
    end else if (state == S_SCAN && rd_vld) begin
      if (match && !found) begin
        hit_idx <= rd_idx;
        hit_ent <= rdata;
      end
      if (!best_seen || (rdata.use_time < best_time)) begin
        best_seen <= 1'b1;
        best_time <= rdata.use_time;
        best_idx  <= rd_idx;
        best_live <= rdata.status != nac_pkg::ES_UNUSED;
      end
    end
    rd_idx <= cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init_done <= 1'b0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_vld <= issuing;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + (AW+1)'(1);
          if (cnt == (AW+1)'(ENTRIES - 1)) begin
            cnt <= '0;
            if (init_done) begin
              state <= S_FINISH;
            end else begin
              init_done <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cnt   <= '0;
            found <= 1'b0;
            case (q_head.op)
              nac_pkg::OP_FLUSH:  state <= S_CLEAR;
              nac_pkg::OP_IGNORE: state <= S_FINISH;
              default:            state <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            cnt <= cnt + (AW+1)'(1);
          end
          if (rd_vld && match) begin
            found <= 1'b1;
          end
          if (!issuing && !rd_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/neighbor_address_cache_top.sv]
// Channel  Direction  Signals                      Contents
// s_axis   in         s_tvalid s_tready s_tdata    tdata: addr_high, addr_low, medium_req,
//                     s_tuser                      mac_addr, now_ms; tuser: command
// m_axis   out        m_tvalid m_tready m_tdata    tdata: mac_out, entry_index, replaced_live;
//                     m_tuser                      tuser: status
// cfg      in         cfg_valid cfg_ready cfg_data stale_age_ms
//
// Lookup, refresh, enter and delete scan every entry through one table read port.
// Flush clears the table, writing one entry per cycle; unknown commands skip the scan.
// After reset a clearing sweep over all ENTRIES entries runs with s_tready low.
// A two-deep request queue lets the input side keep accepting while a result waits on m_tready.
`include "neighbor_address_cache_top_macros.svh"

module neighbor_address_cache_top #(
  parameter int ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [215:0] s_tdata,   // addr_high, addr_low, medium_req, mac_addr, now_ms, pad
  input  logic [2:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // mac_out, entry_index, replaced_live, pad
  output logic [3:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic                stale_age;
  logic [31:0]         stale_age_ms;
  nac_pkg::back_stat_t stat;
  logic                push;
  nac_pkg::req_t       push_req;
  logic                pop;
  logic                q_valid;
  logic                q_full;
  logic [1:0]          q_count;
  nac_pkg::req_t       q_head;
  logic                res_has_mac;

  assign cfg_ready = 1'b1;
  assign stale_age = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_age_ms <= nac_pkg::STALE_RESET[31:0];
    end else if (stale_age) begin
      stale_age_ms <= cfg_data;
    end
  end

  nac_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  nac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_count  (q_count),
    .q_head   (q_head)
  );

  nac_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .stale_age (stale_age_ms),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  assign res_has_mac = (m_tuser == nac_pkg::ST_RESOLVED) || (m_tuser == nac_pkg::ST_STALE) ||
                       (m_tuser == nac_pkg::ST_UPDATED) || (m_tuser == nac_pkg::ST_ADDED);

  `NAC_ASSERT(a_no_accept_in_sweep, !stat.init_done |-> !s_tready, "accept during clear sweep")
  `NAC_ASSERT(a_queue_bound, q_count != 2'd3, "request queue overflow")
  `NAC_ASSERT(a_mac_zero, (m_tvalid && !res_has_mac) |-> (m_tdata[47:0] == 48'd0), "mac on unresolved")
  `NAC_ASSERT_NEXT(a_pop_when_idle, pop, !stat.idle, "back end took two requests at once")

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 256;
  localparam logic [2:0] CMD_UNKNOWN = nac_pkg::CMD_FLUSH + 3'd1;
  localparam int POOL_SIZE = 40;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [2:0]  media;
    logic [47:0] mac;
    logic [31:0] now;
  } cache_req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] mac;
    logic [7:0]  index;
    logic        live;
  } cache_resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [215:0] s_tdata = '0;   // addr_high, addr_low, medium_req, mac_addr, now_ms, pad
  logic [2:0]   s_tuser = '0;   // command
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;        // mac_out, entry_index, replaced_live, pad
  logic [3:0]   m_tuser;        // status
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  neighbor_address_cache_top #(.ENTRIES(NUM_ENTRIES)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the neighbor table
  logic [1:0]  nb_state [NUM_ENTRIES];
  logic [63:0] nb_ahigh [NUM_ENTRIES];
  logic [63:0] nb_alow  [NUM_ENTRIES];
  logic [2:0]  nb_medium[NUM_ENTRIES];
  logic [47:0] nb_mac   [NUM_ENTRIES];
  logic [31:0] nb_used  [NUM_ENTRIES];
  logic [31:0] nb_confirmed[NUM_ENTRIES];
  logic [31:0] stale_limit = nac_pkg::STALE_RESET;

  cache_req_t  pending_reqs[$];
  cache_resp_t expected_resps[$];
  int          failures = 0;
  bit          idling_on = 1'b1;

  function automatic void clear_slot(int i);
    nb_state[i] = nac_pkg::ES_UNUSED;
    nb_ahigh[i] = '0;
    nb_alow[i] = '0;
    nb_medium[i] = '0;
    nb_mac[i] = '0;
    nb_used[i] = '0;
    nb_confirmed[i] = '0;
  endfunction

  function automatic int least_recent_slot();
    int best;
    best = 0;
    for (int i = 1; i < NUM_ENTRIES; i++)
      if (nb_used[i] < nb_used[best]) best = i;
    return best;
  endfunction

  function automatic void claim_slot(int i, cache_req_t r, logic [1:0] st);
    nb_state[i] = st;
    nb_ahigh[i] = r.addr_high;
    nb_alow[i] = r.addr_low;
    nb_medium[i] = r.media;
    nb_mac[i] = (st == nac_pkg::ES_RESOLVED) ? r.mac : '0;
    nb_used[i] = r.now;
    nb_confirmed[i] = (st == nac_pkg::ES_RESOLVED) ? r.now : '0;
  endfunction

  function automatic cache_resp_t resolve_request(cache_req_t r);
    cache_resp_t res;
    int hit;
    bit found;
    bit ok;
    res = '0;
    hit = 0;
    found = 0;
    if (r.cmd inside {nac_pkg::CMD_LOOKUP, nac_pkg::CMD_REFRESH, nac_pkg::CMD_ENTER}) begin
      for (int i = 0; i < NUM_ENTRIES && !found; i++) begin
        ok = (r.cmd == nac_pkg::CMD_LOOKUP) ?
             (nb_state[i] != nac_pkg::ES_UNUSED) :
             (nb_state[i] inside {nac_pkg::ES_RESOLVED, nac_pkg::ES_WAITING});
        if (ok && nb_medium[i] == r.media && nb_ahigh[i] == r.addr_high &&
            nb_alow[i] == r.addr_low) begin
          hit = i;
          found = 1;
        end
      end
    end
    case (r.cmd)
      nac_pkg::CMD_LOOKUP: begin
        if (!found) begin
          hit = least_recent_slot();
          res.live = nb_state[hit] != nac_pkg::ES_UNUSED;
          claim_slot(hit, r, nac_pkg::ES_WAITING);
          res.status = nac_pkg::ST_PENDING_NEW;
        end else begin
          nb_used[hit] = r.now;
          if (nb_state[hit] == nac_pkg::ES_WAITING) begin
            res.status = nac_pkg::ST_PENDING_OLD;
          end else begin
            res.mac = nb_mac[hit];
            if (r.now - nb_confirmed[hit] > stale_limit) begin
              clear_slot(hit);
              res.status = nac_pkg::ST_STALE;
            end else begin
              res.status = nac_pkg::ST_RESOLVED;
            end
          end
        end
        res.index = hit[7:0];
      end
      nac_pkg::CMD_REFRESH, nac_pkg::CMD_ENTER: begin
        if (found) begin
          nb_state[hit] = nac_pkg::ES_RESOLVED;
          nb_mac[hit] = r.mac;
          nb_used[hit] = r.now;
          nb_confirmed[hit] = r.now;
          res.status = nac_pkg::ST_UPDATED;
          res.mac = r.mac;
          res.index = hit[7:0];
        end else if (r.cmd == nac_pkg::CMD_REFRESH) begin
          res.status = nac_pkg::ST_IGNORED;
        end else begin
          hit = least_recent_slot();
          res.live = nb_state[hit] != nac_pkg::ES_UNUSED;
          claim_slot(hit, r, nac_pkg::ES_RESOLVED);
          res.status = nac_pkg::ST_ADDED;
          res.mac = r.mac;
          res.index = hit[7:0];
        end
      end
      nac_pkg::CMD_DELETE: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (nb_state[i] != nac_pkg::ES_UNUSED && nb_ahigh[i] == r.addr_high &&
              nb_alow[i] == r.addr_low) begin
            if (!found) begin
              hit = i;
              found = 1;
            end
            clear_slot(i);
          end
        end
        res.status = found ? nac_pkg::ST_DELETED : nac_pkg::ST_DELETE_MISS;
        res.index = found ? hit[7:0] : 8'd0;
      end
      nac_pkg::CMD_FLUSH: begin
        for (int i = 0; i < NUM_ENTRIES; i++) clear_slot(i);
        res.status = nac_pkg::ST_FLUSHED;
      end
      default: res.status = nac_pkg::ST_IGNORED;
    endcase
    return res;
  endfunction

  // request driver
  cache_req_t drv_item;
  int         drv_gap = 0;
  always @(posedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_resps.push_back(resolve_request(drv_item));
        nv = 1'b0;
      end
      if (!nv) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_reqs.size() > 0) begin
          if (idling_on && $urandom_range(0, 5) == 0) begin
            drv_gap = $urandom_range(1, 12);
          end else begin
            drv_item = pending_reqs.pop_front();
            s_tdata <= {5'd0, drv_item.now, drv_item.mac, drv_item.media,
                        drv_item.addr_low, drv_item.addr_high};
            s_tuser <= drv_item.cmd;
            nv = 1'b1;
          end
        end
      end
    end
    s_tvalid <= nv;
  end

  // result receiver with random backpressure
  int rcv_gap = 0;
  always @(posedge clk) begin
    logic nr;
    cache_resp_t want;
    nr = 1'b1;
    if (rst) begin
      nr = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected result transaction: status %0d", m_tuser);
          failures++;
        end else begin
          want = expected_resps.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            failures++;
          end
          if (m_tdata[47:0] !== want.mac) begin
            $error("mac_out: expected %h, actual %h", want.mac, m_tdata[47:0]);
            failures++;
          end
          if (m_tdata[55:48] !== want.index) begin
            $error("entry_index: expected %0d, actual %0d", want.index, m_tdata[55:48]);
            failures++;
          end
          if (m_tdata[56] !== want.live) begin
            $error("replaced_live: expected %0d, actual %0d", want.live, m_tdata[56]);
            failures++;
          end
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        nr = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        rcv_gap = $urandom_range(0, 11);
        nr = 1'b0;
      end
    end
    m_tready <= nr;
  end

  // address pool so that hits, refreshes and deletes happen often
  logic [63:0] pool_high[POOL_SIZE];
  logic [63:0] pool_low[POOL_SIZE];
  logic [31:0] clock_ms;

  task automatic push_req(logic [2:0] cmd, logic [63:0] ah, logic [63:0] al,
                          logic [2:0] med, logic [47:0] mac, logic [31:0] now);
    cache_req_t r;
    r.cmd = cmd;
    r.addr_high = ah;
    r.addr_low = al;
    r.media = med;
    r.mac = mac;
    r.now = now;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(int count);
    logic [2:0]  cmd;
    logic [63:0] ah;
    logic [63:0] al;
    int          k;
    int          roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) cmd = nac_pkg::CMD_LOOKUP;
      else if (roll < 50) cmd = nac_pkg::CMD_REFRESH;
      else if (roll < 80) cmd = nac_pkg::CMD_ENTER;
      else if (roll < 93) cmd = nac_pkg::CMD_DELETE;
      else if (roll < 95) cmd = nac_pkg::CMD_FLUSH;
      else cmd = 3'($urandom_range(CMD_UNKNOWN, 7));
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        ah = pool_high[k];
        al = pool_low[k];
      end else begin
        ah = {$urandom, $urandom};
        al = {$urandom, $urandom};
      end
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 250000);
      push_req(cmd, ah, al, $urandom_range(0, 1) ? 3'd1 : 3'($urandom_range(0, 7)),
               {$urandom, $urandom}, clock_ms);
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_stale_limit(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stale_limit = value;
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    for (int i = 0; i < NUM_ENTRIES; i++) clear_slot(i);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_high[i] = (i % 3 == 0) ? 64'h0 : {$urandom, $urandom};
      pool_low[i] = (i % 3 == 0) ? {32'h0000ffff, $urandom} : {$urandom, $urandom};
    end
    clock_ms = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: default stale age from reset
    push_req(nac_pkg::CMD_LOOKUP, 64'd0, 64'd0, 3'd0, 48'd0, 32'd0);
    push_req(nac_pkg::CMD_LOOKUP, 64'd0, 64'd0, 3'd0, 48'd0, 32'd5);  // pending existing
    push_req(nac_pkg::CMD_REFRESH, 64'd0, 64'd0, 3'd0, 48'h0123456789ab, 32'd10);
    push_req(nac_pkg::CMD_LOOKUP, 64'd0, 64'd0, 3'd0, 48'd0, 32'd900010);  // exactly at limit
    push_req(nac_pkg::CMD_LOOKUP, 64'd0, 64'd0, 3'd0, 48'd0, 32'd900011);  // stale clear
    push_req(nac_pkg::CMD_REFRESH, ones, ones, 3'd7, 48'hffffffffffff, 32'hffffffff);
    push_req(nac_pkg::CMD_ENTER, ones, ones, 3'd7, 48'hffffffffffff, 32'hfffffff0);
    push_req(nac_pkg::CMD_ENTER, ones, ones, 3'd3, 48'h5a5a5a5a5a5a, 32'hfffffff1);
    push_req(nac_pkg::CMD_LOOKUP, ones, ones, 3'd7, 48'd0, 32'd20);   // wrapped age
    push_req(nac_pkg::CMD_ENTER, ones, ones, 3'd7, 48'ha5a5a5a5a5a5, 32'd30);  // update
    push_req(nac_pkg::CMD_DELETE, ones, ones, 3'd0, 48'd0, 32'd40);   // both media
    push_req(nac_pkg::CMD_DELETE, ones, ones, 3'd0, 48'd0, 32'd41);   // miss
    push_req(CMD_UNKNOWN, ones, ones, 3'd7, 48'hffffffffffff, 32'd50);
    push_req(CMD_UNKNOWN + 3'd1, 64'd1, 64'd2, 3'd1, 48'd1, 32'd51);
    push_req(3'd7, 64'd1, 64'd2, 3'd1, 48'd1, 32'd52);
    push_req(nac_pkg::CMD_ENTER, 64'h8000000000000000, 64'd1, 3'd4, 48'h800000000001, 32'd60);
    push_req(nac_pkg::CMD_FLUSH, 64'd0, 64'd0, 3'd0, 48'd0, 32'd70);
    push_req(nac_pkg::CMD_LOOKUP, 64'h8000000000000000, 64'd1, 3'd4, 48'd0, 32'd80);
    push_req(nac_pkg::CMD_DELETE, 64'h8000000000000000, 64'd1, 3'd2, 48'd0, 32'd90);
    wait_idle();

    push_random(400);
    wait_idle();
    write_stale_limit(32'd0);
    push_random(300);
    wait_idle();
    write_stale_limit(32'hffffffff);
    push_random(300);
    wait_idle();
    write_stale_limit($urandom_range(50000, 400000));
    push_random(300);
    wait_idle();
    write_stale_limit(nac_pkg::STALE_RESET);
    idling_on = 1'b0;
    push_random(250);
    wait_idle();
    repeat (300) @(posedge clk);

    if (failures == 0 && expected_resps.size() == 0) begin
      $display("neighbor_address_cache_top regression: pass");
    end else begin
      $display("neighbor_address_cache_top regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("neighbor_address_cache_top regression: fail");
    $finish;
  end

endmodule
